@@ rtl/fsq_pkg.sv @@
`timescale 1ns / 1ps

package fsq_pkg;

  localparam logic [4:0] LETTER_I = 5'd8;
  localparam logic [4:0] LETTER_J = 5'd9;
  localparam logic [4:0] LETTER_X = 5'd23;
  localparam logic [4:0] ALPHA_LAST = 5'd25;
  localparam logic [4:0] CELLS = 5'd25;
  localparam logic [6:0] ASCII_A = 7'd97;
  localparam logic [7:0] CASE_GAP = 8'd32;

  localparam logic [1:0] CMD_KEY_ONE = 2'd0;
  localparam logic [1:0] CMD_KEY_TWO = 2'd1;
  localparam logic [1:0] CMD_TEXT = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_KEY,
    ST_FILL,
    ST_TEXT,
    ST_LOOK,
    ST_MAP,
    ST_OUT_A,
    ST_OUT_B
  } fsm_state_t;

  typedef struct packed {
    logic       ok;
    logic [4:0] code;
  } letter_t;

  typedef struct packed {
    logic [2:0] row;
    logic [2:0] col;
  } cell_t;

  // ASCII to letter code 0..25, upper case folded to lower
  function automatic letter_t fold_letter(input logic [7:0] ch);
    logic [7:0] lc;
    letter_t res;
    lc = (ch inside {[8'd65:8'd90]}) ? ch + CASE_GAP : ch;
    res.ok = lc inside {[8'd97:8'd122]};
    res.code = lc[4:0] - 5'd1;
    return res;
  endfunction

  function automatic logic [4:0] plain_pos(input logic [4:0] code);
    logic [4:0] c;
    c = (code == LETTER_J) ? LETTER_I : code;
    return (c < LETTER_J) ? c : c - 5'd1;
  endfunction

  function automatic logic [4:0] plain_letter(input logic [4:0] pos);
    return (pos < LETTER_J) ? pos : pos + 5'd1;
  endfunction

  // split a square position (0..24) into row and column
  function automatic cell_t split_pos(input logic [4:0] pos);
    cell_t res;
    logic [4:0] base;
    if (pos >= 5'd20) begin
      res.row = 3'd4;
    end else if (pos >= 5'd15) begin
      res.row = 3'd3;
    end else if (pos >= 5'd10) begin
      res.row = 3'd2;
    end else if (pos >= 5'd5) begin
      res.row = 3'd1;
    end else begin
      res.row = 3'd0;
    end
    base = {res.row, 2'b00} + {2'b00, res.row};
    res.col = 3'(pos - base);
    return res;
  endfunction

  function automatic logic [4:0] join_pos(input logic [2:0] row, input logic [2:0] col);
    return {row, 2'b00} + {2'b00, row} + {2'b00, col};
  endfunction

endpackage

@@ rtl/four_square_cipher.sv @@
`timescale 1ns / 1ps

// Four-square digraph cipher (25 letters, j read as i). s_tuser selects a key
// letter for square one (0), square two (1) or a text letter (2); s_tlast
// closes a key or a text. Text letters pair up and each completed pair comes
// out as two lower case letters, encrypted or decrypted per the mode register.
// A key or unpaired text letter passes IDLE and KEY or TEXT; the last key
// letter adds a walk over the alphabet that fills the rest of the square with
// the unused letters; a text letter that completes a pair also passes LOOK
// and MAP, then the two output handshakes. One item is in work at a time: a
// small sequencer steers it through the shared lookup and row/column split path.
module four_square_cipher (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic       cfg_wdata,  // mode: 0 encrypt, 1 decrypt
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,    // [7:0] letter
  input  logic [1:0] s_tuser,    // [1:0] cmd
  input  logic       s_tlast,    // last
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,    // [6:0] out_letter, [7] zero
  output logic       m_tuser,    // [0] last_of_pair
  output logic       m_tlast     // end_of_text
);

  fsq_pkg::fsm_state_t state, state_next;

  logic       mode;
  logic [1:0] item_cmd;
  logic [4:0] item_code;
  logic       item_ok;
  logic       item_last;

  logic [4:0] sq_one [25];
  logic [4:0] sq_two [25];
  logic [4:0] pos_one [26];
  logic [4:0] pos_two [26];
  logic [25:0] used;
  logic [4:0] fill;
  logic [4:0] walk;
  logic [4:0] pend_letter;
  logic       pend_valid;

  logic [4:0] first, second;
  logic [4:0] pa, pb;
  logic [4:0] res_one, res_two;
  logic       end_flag;

  fsq_pkg::letter_t in_letter;
  logic [4:0] place_code;
  logic       place_ok;
  logic       sq_we;
  logic       emit;
  logic [4:0] look_a, look_b;
  fsq_pkg::cell_t cell_a, cell_b;
  logic [4:0] idx_one, idx_two;

  assign in_letter = fsq_pkg::fold_letter(s_tdata);

  // key placement: the new key letter, or the current letter of the walk
  always_comb begin
    if (state == fsq_pkg::ST_KEY) begin
      place_code = item_code;
      place_ok = item_ok && item_code != fsq_pkg::LETTER_J && !used[item_code];
    end else begin
      place_code = walk;
      place_ok = state == fsq_pkg::ST_FILL && walk != fsq_pkg::LETTER_J && !used[walk];
    end
    sq_we = place_ok && fill < fsq_pkg::CELLS;
  end

  assign emit = pend_valid ? (item_ok || item_last) : (item_ok && item_last);

  always_comb begin
    look_a = mode ? pos_one[first] : fsq_pkg::plain_pos(first);
    look_b = mode ? pos_two[second] : fsq_pkg::plain_pos(second);
    cell_a = fsq_pkg::split_pos(pa);
    cell_b = fsq_pkg::split_pos(pb);
    idx_one = fsq_pkg::join_pos(cell_a.row, cell_b.col);
    idx_two = fsq_pkg::join_pos(cell_b.row, cell_a.col);
  end

  always_comb begin
    state_next = state;
    case (state)
      fsq_pkg::ST_IDLE: begin
        if (s_tvalid) begin
          case (s_tuser)
            fsq_pkg::CMD_KEY_ONE, fsq_pkg::CMD_KEY_TWO: state_next = fsq_pkg::ST_KEY;
            fsq_pkg::CMD_TEXT: state_next = fsq_pkg::ST_TEXT;
            default: state_next = fsq_pkg::ST_IDLE;
          endcase
        end
      end
      fsq_pkg::ST_KEY: state_next = item_last ? fsq_pkg::ST_FILL : fsq_pkg::ST_IDLE;
      fsq_pkg::ST_FILL: begin
        if (walk == fsq_pkg::ALPHA_LAST) begin
          state_next = fsq_pkg::ST_IDLE;
        end
      end
      fsq_pkg::ST_TEXT: state_next = emit ? fsq_pkg::ST_LOOK : fsq_pkg::ST_IDLE;
      fsq_pkg::ST_LOOK: state_next = fsq_pkg::ST_MAP;
      fsq_pkg::ST_MAP: state_next = fsq_pkg::ST_OUT_A;
      fsq_pkg::ST_OUT_A: begin
        if (m_tready) begin
          state_next = fsq_pkg::ST_OUT_B;
        end
      end
      fsq_pkg::ST_OUT_B: begin
        if (m_tready) begin
          state_next = fsq_pkg::ST_IDLE;
        end
      end
      default: state_next = fsq_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fsq_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= 1'b0;
      used <= '0;
      fill <= '0;
      walk <= '0;
      pend_letter <= '0;
      pend_valid <= 1'b0;
      for (int i = 0; i < 25; i++) begin
        sq_one[i] <= fsq_pkg::plain_letter(5'(i));
        sq_two[i] <= fsq_pkg::plain_letter(5'(i));
      end
      for (int i = 0; i < 26; i++) begin
        pos_one[i] <= fsq_pkg::plain_pos(5'(i));
        pos_two[i] <= fsq_pkg::plain_pos(5'(i));
      end
    end else begin
      if (cfg_we) begin
        mode <= cfg_wdata;
      end
      if (sq_we) begin
        if (item_cmd == fsq_pkg::CMD_KEY_ONE) begin
          sq_one[fill] <= place_code;
          pos_one[place_code] <= fill;
        end else begin
          sq_two[fill] <= place_code;
          pos_two[place_code] <= fill;
        end
      end
      // end of the walk rewinds the fill position for the next key
      if (state == fsq_pkg::ST_FILL && walk == fsq_pkg::ALPHA_LAST) begin
        fill <= '0;
      end else if (sq_we) begin
        fill <= fill + 5'd1;
      end
      case (state)
        fsq_pkg::ST_KEY: begin
          if (place_ok) begin
            used[item_code] <= 1'b1;
          end
          walk <= '0;
        end
        fsq_pkg::ST_FILL: begin
          walk <= walk + 5'd1;
          if (walk == fsq_pkg::ALPHA_LAST) begin
            used <= '0;
          end
        end
        fsq_pkg::ST_TEXT: begin
          if (emit) begin
            pend_valid <= 1'b0;
            pend_letter <= '0;
          end else if (!pend_valid && item_ok) begin
            pend_valid <= 1'b1;
            pend_letter <= item_code;
          end
        end
        default: ;
      endcase
    end
  end

  // payload path
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      item_cmd <= s_tuser;
      item_code <= in_letter.code;
      item_ok <= in_letter.ok;
      item_last <= s_tlast;
    end
    if (state == fsq_pkg::ST_TEXT) begin
      if (pend_valid) begin
        first <= (pend_letter == fsq_pkg::LETTER_J) ? fsq_pkg::LETTER_I : pend_letter;
      end else begin
        first <= (item_code == fsq_pkg::LETTER_J) ? fsq_pkg::LETTER_I : item_code;
      end
      if (pend_valid && item_ok) begin
        second <= (item_code == fsq_pkg::LETTER_J) ? fsq_pkg::LETTER_I : item_code;
      end else begin
        second <= fsq_pkg::LETTER_X;
      end
      end_flag <= item_last;
    end
    if (state == fsq_pkg::ST_LOOK) begin
      pa <= (look_a >= fsq_pkg::CELLS) ? 5'd0 : look_a;
      pb <= (look_b >= fsq_pkg::CELLS) ? 5'd0 : look_b;
    end
    if (state == fsq_pkg::ST_MAP) begin
      res_one <= mode ? fsq_pkg::plain_letter(idx_one) : sq_one[idx_one];
      res_two <= mode ? fsq_pkg::plain_letter(idx_two) : sq_two[idx_two];
    end
  end

  assign s_tready = state == fsq_pkg::ST_IDLE;
  assign m_tvalid = state == fsq_pkg::ST_OUT_A || state == fsq_pkg::ST_OUT_B;
  assign m_tuser = state == fsq_pkg::ST_OUT_B;
  assign m_tlast = state == fsq_pkg::ST_OUT_B && end_flag;
  assign m_tdata = {1'b0, fsq_pkg::ASCII_A + {2'b00, (m_tuser ? res_two : res_one)}};

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(s_tready && m_tvalid))
    else $error("input taken while a result is pending");

  a_fill_range: assert property (@(posedge clk) disable iff (rst)
    fill <= fsq_pkg::CELLS)
    else $error("fill position past the square");

  a_pair_order: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && !m_tuser) |=> (m_tvalid && m_tuser))
    else $error("first letter of a pair not followed by the second");

  a_end_on_second: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tlast) |-> m_tuser)
    else $error("end of text on the first letter of a pair");

endmodule

@@ sim/four_square_cipher_test.sv @@
`timescale 1ns / 1ps

module four_square_cipher_test;

  localparam logic [1:0] CMD_SPARE = 2'd3;
  localparam int ITEM_TOTAL = 1700;
  localparam int IDLE_PCT = 17;
  localparam int SETTLE_CYCLES = 40;

  typedef struct packed {
    logic [7:0] data;
    logic       pair_end;
    logic       text_end;
  } cipher_out_t;

  // Tracks both keyed squares and the open pair; holds the letters due out.
  class cipher_scoreboard;
    logic [4:0]  sq_letter [2][25];
    logic [4:0]  sq_pos [2][26];
    bit          used [26];
    int          fill;
    logic [4:0]  held;
    bit          held_ok;
    bit          mode;
    cipher_out_t due [$];
    int          errors;

    function new();
      for (int k = 0; k < 25; k++) begin
        sq_letter[0][k] = 5'(letter_of(k));
        sq_letter[1][k] = 5'(letter_of(k));
      end
      for (int k = 0; k < 26; k++) begin
        sq_pos[0][k] = 5'(cell_of(k));
        sq_pos[1][k] = 5'(cell_of(k));
        used[k] = 1'b0;
      end
      fill = 0;
      held = '0;
      held_ok = 1'b0;
      mode = 1'b0;
      errors = 0;
    endfunction

    // position of a letter in the plain alphabet square, j read as i
    function int cell_of(int c);
      if (c == fsq_pkg::LETTER_J) c = 8;
      return (c < fsq_pkg::LETTER_J) ? c : c - 1;
    endfunction

    function int letter_of(int p);
      return (p < fsq_pkg::LETTER_J) ? p : p + 1;
    endfunction

    function void place(int s, int c);
      if (fill < 25) begin
        sq_letter[s][fill] = 5'(c);
        sq_pos[s][c] = 5'(fill);
        fill++;
      end
    endfunction

    task report(string msg);
      $display("ERROR at %0t: %s", $realtime, msg);
      errors++;
    endtask

    function void note_input(logic [1:0] cmd, logic [7:0] ch, logic last);
      int c;
      bit ok;
      int s;
      int first, second, p1, p2, ar, ac, br, bc, r1, r2;
      logic [7:0] lc;
      cipher_out_t nxt;
      lc = (ch >= 8'd65 && ch <= 8'd90) ? ch + 8'd32 : ch;
      ok = (lc >= 8'd97 && lc <= 8'd122);
      c = ok ? int'(lc) - 97 : 0;
      if (cmd == fsq_pkg::CMD_KEY_ONE || cmd == fsq_pkg::CMD_KEY_TWO) begin
        s = (cmd == fsq_pkg::CMD_KEY_TWO) ? 1 : 0;
        if (ok && c != fsq_pkg::LETTER_J && !used[c]) begin
          used[c] = 1'b1;
          place(s, c);
        end
        if (last) begin
          for (int k = 0; k < 26; k++)
            if (k != fsq_pkg::LETTER_J && !used[k]) place(s, k);
          for (int k = 0; k < 26; k++) used[k] = 1'b0;
          fill = 0;
        end
        return;
      end
      if (cmd != fsq_pkg::CMD_TEXT) return;
      if (ok && !held_ok) begin
        held = 5'(c);
        held_ok = 1'b1;
        if (!last) return;
        ok = 1'b0;
      end
      if (!held_ok) return;
      if (!ok) begin
        if (!last) return;
        c = fsq_pkg::LETTER_X;
      end
      first = (held == fsq_pkg::LETTER_J) ? 8 : int'(held);
      second = (c == fsq_pkg::LETTER_J) ? 8 : c;
      if (mode == 1'b0) begin
        p1 = cell_of(first);
        p2 = cell_of(second);
      end else begin
        p1 = sq_pos[0][first];
        p2 = sq_pos[1][second];
      end
      ar = p1 / 5;
      ac = p1 % 5;
      br = p2 / 5;
      bc = p2 % 5;
      if (mode == 1'b0) begin
        r1 = sq_letter[0][ar * 5 + bc];
        r2 = sq_letter[1][br * 5 + ac];
      end else begin
        r1 = letter_of(ar * 5 + bc);
        r2 = letter_of(br * 5 + ac);
      end
      nxt = '{data: {1'b0, fsq_pkg::ASCII_A + 7'(r1)}, pair_end: 1'b0, text_end: 1'b0};
      due = {due, nxt};
      nxt = '{data: {1'b0, fsq_pkg::ASCII_A + 7'(r2)}, pair_end: 1'b1, text_end: last};
      due = {due, nxt};
      held_ok = 1'b0;
      held = '0;
    endfunction

    task check_result(logic [7:0] data, logic pair_end, logic text_end);
      cipher_out_t want;
      if (due.size() == 0) begin
        report($sformatf("unexpected item data %h", data));
        return;
      end
      want = due.pop_front();
      if (data !== want.data)
        report($sformatf("letter got %h want %h", data, want.data));
      if (pair_end !== want.pair_end)
        report($sformatf("last_of_pair got %b want %b", pair_end, want.pair_end));
      if (text_end !== want.text_end)
        report($sformatf("end_of_text got %b want %b", text_end, want.text_end));
    endtask
  endclass

  logic       clk;
  logic       rst;
  logic       cfg_we;
  logic       cfg_wdata;
  logic       s_tvalid;
  logic       s_tready;
  logic [7:0] s_tdata;
  logic [1:0] s_tuser;
  logic       s_tlast;
  logic       m_tvalid;
  logic       m_tready;
  logic [7:0] m_tdata;
  logic       m_tuser;
  logic       m_tlast;

  cipher_scoreboard sb;
  int  sent_items;
  bit  tx_steady;
  bit  rx_steady;

  four_square_cipher u_top (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser, m_tlast);
    m_tready <= rx_steady || ($urandom_range(99) >= IDLE_PCT);
  end

  task automatic send_item(logic [1:0] cmd, logic [7:0] ch, logic last);
    while (!tx_steady && $urandom_range(99) < IDLE_PCT) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= cmd;
    s_tdata <= ch;
    s_tlast <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_input(cmd, ch, last);
    sent_items++;
  endtask

  task automatic send_word(logic [1:0] cmd, string s);
    for (int i = 0; i < s.len(); i++) send_item(cmd, s[i], i == s.len() - 1);
  endtask

  // mostly letters of either case, some j, some arbitrary bytes
  function automatic logic [7:0] rand_char();
    int r;
    logic [7:0] ch;
    r = $urandom_range(99);
    if (r < 8) return 8'($urandom_range(255));
    ch = (r < 12) ? 8'd106 : 8'(97 + $urandom_range(25));
    if ($urandom_range(1)) ch = ch - 8'd32;
    return ch;
  endfunction

  task automatic send_run(logic [1:0] cmd, int len);
    for (int i = 0; i < len; i++) send_item(cmd, rand_char(), i == len - 1);
  endtask

  // hold off the sender until everything owed has come out, then let the
  // fill walk finish
  task automatic drain();
    int n;
    s_tvalid <= 1'b0;
    n = 0;
    while (sb.due.size() != 0 && n < 20000) begin
      @(posedge clk);
      n++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_mode(bit m);
    cfg_we <= 1'b1;
    cfg_wdata <= m;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.mode = m;
  endtask

  initial begin
    #1000000;
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    int pick;
    sb = new();
    sent_items = 0;
    tx_steady = 1'b0;
    rx_steady = 1'b0;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = 1'b0;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = '0;
    s_tlast = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // plain squares: lone letter padded, then a close with nothing held
    send_item(fsq_pkg::CMD_TEXT, "a", 1'b1);
    send_item(fsq_pkg::CMD_TEXT, "!", 1'b1);
    send_word(fsq_pkg::CMD_KEY_ONE, "EjAm#k");
    // repeated letter, key closed on a dropped character
    send_word(fsq_pkg::CMD_KEY_TWO, "KeYe!");
    send_word(fsq_pkg::CMD_TEXT, "Hej1z");
    send_item(fsq_pkg::CMD_TEXT, "q", 1'b0);
    send_item(fsq_pkg::CMD_TEXT, 8'hff, 1'b1);
    send_item(CMD_SPARE, "a", 1'b1);
    // one key spread over both squares
    send_item(fsq_pkg::CMD_KEY_TWO, "c", 1'b0);
    send_item(fsq_pkg::CMD_KEY_ONE, "D", 1'b1);
    drain();
    set_mode(1'b1);
    send_word(fsq_pkg::CMD_TEXT, "fgX");
    drain();
    set_mode(1'b0);

    while (sent_items < ITEM_TOTAL) begin
      tx_steady = (sent_items >= 600 && sent_items < 900);
      rx_steady <= (sent_items >= 600 && sent_items < 900);
      pick = $urandom_range(99);
      if (pick < 10) begin
        drain();
        set_mode($urandom_range(1));
      end else if (pick < 28) begin
        send_run(fsq_pkg::CMD_KEY_ONE, $urandom_range(1, 28));
      end else if (pick < 46) begin
        send_run(fsq_pkg::CMD_KEY_TWO, $urandom_range(1, 28));
      end else if (pick < 86) begin
        send_run(fsq_pkg::CMD_TEXT, $urandom_range(1, 30));
      end else begin
        repeat ($urandom_range(1, 6))
          send_item(2'($urandom_range(3)), 8'($urandom_range(255)), $urandom_range(9) == 0);
      end
    end

    drain();
    if (sb.due.size() != 0) sb.report($sformatf("%0d items never came", sb.due.size()));
    if (sb.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/fsq_pkg.sv
rtl/four_square_cipher.sv
sim/four_square_cipher_test.sv
